// File: rtl/core/ffra_pkg.sv
`default_nettype none

package ffra_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 36;

    localparam int FIELD_ADDR_W = 36;
    localparam int LEN_W        = 37;
    localparam int SHIFT_W      = 5;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 2;

    localparam logic [LEN_W-1:0]   REGION_SIZE_RST = 37'd34359738368;
    localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_RST = 5'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_SHIFT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_START = 2'd2,
        REQ_STOP  = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_FIT      = 3'd1,
        ST_FULL        = 3'd2,
        ST_BAD_ADDR    = 3'd3,
        ST_NOT_STARTED = 3'd4,
        ST_ALREADY     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE,
        S_SHIFT,
        S_SPLIT_LO,
        S_SPLIT_HI,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [LEN_W-1:0]        alloc_size;
        logic [FIELD_ADDR_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] alloc_addr;
        logic [STATUS_W-1:0]     status;
        logic [LEN_W-1:0]        free_bytes;
        logic [LEN_W-1:0]        used_bytes;
    } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/ffra_mem.sv
`default_nettype none

module ffra_mem #(
    parameter int WIDTH = 74,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/first_fit_region_allocator.sv
// First-fit region allocator.
// Requests enter on in_valid/in_ready (in_data: req_type, alloc_size,
// free_addr); one result per request leaves on out_valid/out_ready
// (out_data: alloc_addr, status, free_bytes, used_bytes).
// Configuration (region base, region size, alignment shift) is written on
// cfg_we/cfg_idx/cfg_wdata with no wait; the user must write it only while
// the block is idle, since the block itself does not enforce this.
// The block table lives in one synchronous RAM of MAX_BLOCKS entries with
// one read and one write port; the block handles one request at a time.
// Alloc and free scan the table one entry per cycle until a hit or a miss;
// a split then moves the entries above the hit up one slot, and a merge
// moves them down, one per cycle.
// The result sits in an output register; in_ready rises again as soon as
// that register is loaded, so the next request is taken while a result
// waits. A stalled receiver holds the block in its final step.
// Reset clears the configuration to its defaults, marks the manager
// stopped and empties the table; no clearing pass is needed.
`default_nettype none

module first_fit_region_allocator #(
    parameter int MAX_BLOCKS = ffra_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffra_pkg::ADDR_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ffra_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  wire logic [ffra_pkg::LEN_W-1:0]        cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire ffra_pkg::req_t                    in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output ffra_pkg::rsp_t                         out_data
);

    import ffra_pkg::*;

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int AB  = ADDR_BITS;
    localparam int BW  = (AB < FIELD_ADDR_W) ? AB : FIELD_ADDR_W;
    localparam int RW  = ((AB > LEN_W) ? AB : LEN_W) + 1;
    localparam int SZW = LEN_W + 1;
    localparam int EW  = AB + LEN_W + 1;

    // configuration
    logic [FIELD_ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0]        rsize_reg;
    logic [SHIFT_W-1:0]      shift_reg;

    // control and payload
    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [LEN_W-1:0]        free_reg, free_next;
    logic [LEN_W-1:0]        used_reg, used_next;
    logic                    started_reg, started_next;
    status_t                 status_reg, status_next;
    logic [FIELD_ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]              rtype_reg, rtype_next;
    logic [SZW-1:0]          size_reg, size_next;
    logic [AB-1:0]           faddr_reg, faddr_next;
    logic [CW-1:0]           iss_reg, iss_next;
    logic                    chk_v_reg, chk_v_next;
    logic [IW-1:0]           chk_idx_reg, chk_idx_next;
    logic [IW-1:0]           hit_reg, hit_next;
    logic [EW-1:0]           cur_reg, cur_next;
    logic [EW-1:0]           prev_reg, prev_next;
    logic [CW-1:0]           p_reg, p_next;
    logic [CW-1:0]           n_reg, n_next;
    logic                    wv_reg, wv_next;
    logic [IW-1:0]           wdst_reg, wdst_next;
    logic                    up_reg, up_next;
    logic [1:0]              dsub_reg, dsub_next;
    logic                    outv_reg, outv_next;
    rsp_t                    outd_reg, outd_next;

    // table RAM
    logic          m_we, m_re;
    logic [IW-1:0] m_waddr, m_raddr;
    logic [EW-1:0] m_wdata, m_rdata;

    ffra_mem #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_mem (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // entry fields: {busy, len, start}
    logic [AB-1:0]    rd_start, cur_start, prev_start;
    logic [LEN_W-1:0] rd_len, cur_len, prev_len;
    logic             rd_busy, prev_busy;

    assign rd_start   = m_rdata[AB-1:0];
    assign rd_len     = m_rdata[AB+LEN_W-1:AB];
    assign rd_busy    = m_rdata[EW-1];
    assign cur_start  = cur_reg[AB-1:0];
    assign cur_len    = cur_reg[AB+LEN_W-1:AB];
    assign prev_start = prev_reg[AB-1:0];
    assign prev_len   = prev_reg[AB+LEN_W-1:AB];
    assign prev_busy  = prev_reg[EW-1];

    // start: clip region to the top of the address space
    logic [RW-1:0]    base_ext, room, rsize_ext;
    logic [LEN_W-1:0] st_len;

    assign base_ext  = RW'(base_reg[BW-1:0]);
    assign room      = (RW'(1) << AB) - base_ext;
    assign rsize_ext = RW'(rsize_reg);
    assign st_len    = (rsize_ext > room) ? room[LEN_W-1:0] : rsize_reg;

    // alloc size rounding
    logic [SZW-1:0] align, sz_raw, in_size;

    assign align   = SZW'(1) << shift_reg;
    assign sz_raw  = (SZW'(in_data.alloc_size) + align - SZW'(1)) & ~(align - SZW'(1));
    assign in_size = (sz_raw < align) ? align : sz_raw;

    logic [AB-1:0] in_faddr;
    assign in_faddr = AB'(in_data.free_addr[BW-1:0]);

    // scan and merge decisions
    logic             hit_alloc, fit_exact, hit_free, scan_hit;
    logic             adj_pc, adj_cn, has_next, merge_p, merge_n;
    logic [LEN_W-1:0] merged_len, size37, split_len;
    logic [RW-1:0]    split_sum, rd_start_w, cur_start_w;
    logic [CW-1:0]    src_first;

    assign size37    = size_reg[LEN_W-1:0];
    assign hit_alloc = !rd_busy && (SZW'(rd_len) >= size_reg);
    assign fit_exact = (SZW'(rd_len) == size_reg);
    assign hit_free  = (rd_start == faddr_reg);
    assign scan_hit  = chk_v_reg && ((rtype_reg == REQ_ALLOC) ? hit_alloc : hit_free);

    assign adj_pc   = (RW'(prev_start) + RW'(prev_len)) == RW'(cur_start);
    assign adj_cn   = (RW'(cur_start) + RW'(cur_len)) == RW'(rd_start);
    assign has_next = (CW'(hit_reg) + CW'(1)) < count_reg;
    assign merge_p  = (hit_reg != '0) && !prev_busy && adj_pc;
    assign merge_n  = has_next && !rd_busy && adj_cn;

    assign merged_len = (merge_p ? prev_len : LEN_W'(0)) + cur_len
                      + (merge_n ? rd_len : LEN_W'(0));
    assign src_first  = CW'(hit_reg) + CW'(1) + CW'(merge_n);

    assign split_sum   = RW'(cur_start) + RW'(size_reg);
    assign split_len   = cur_len - size37;
    assign rd_start_w  = RW'(rd_start);
    assign cur_start_w = RW'(cur_start);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        free_next    = free_reg;
        used_next    = used_reg;
        started_next = started_reg;
        status_next  = status_reg;
        addr_next    = addr_reg;
        rtype_next   = rtype_reg;
        size_next    = size_reg;
        faddr_next   = faddr_reg;
        iss_next     = iss_reg;
        chk_v_next   = chk_v_reg;
        chk_idx_next = chk_idx_reg;
        hit_next     = hit_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        wv_next      = wv_reg;
        wdst_next    = wdst_reg;
        up_next      = up_reg;
        dsub_next    = dsub_reg;
        outv_next    = outv_reg;
        outd_next    = outd_reg;
        in_ready     = 1'b0;
        m_we         = 1'b0;
        m_waddr      = '0;
        m_wdata      = '0;
        m_re         = 1'b0;
        m_raddr      = '0;

        if (outv_reg && out_ready)
        begin
            outv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rtype_next  = in_data.req_type;
                    size_next   = in_size;
                    faddr_next  = in_faddr;
                    addr_next   = '0;
                    status_next = ST_OK;
                    iss_next    = '0;
                    chk_v_next  = 1'b0;
                    state_next  = S_DONE;
                    if (in_data.req_type == REQ_START)
                    begin
                        if (started_reg)
                        begin
                            status_next = ST_ALREADY;
                        end
                        else
                        begin
                            started_next = 1'b1;
                            free_next    = st_len;
                            used_next    = '0;
                            count_next   = (st_len != '0) ? CW'(1) : '0;
                            m_we         = (st_len != '0);
                            m_wdata      = {1'b0, st_len, base_ext[AB-1:0]};
                        end
                    end
                    else if (!started_reg)
                    begin
                        status_next = ST_NOT_STARTED;
                    end
                    else if (in_data.req_type == REQ_STOP)
                    begin
                        started_next = 1'b0;
                        count_next   = '0;
                        free_next    = '0;
                        used_next    = '0;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    hit_next = chk_idx_reg;
                    cur_next = m_rdata;
                    if (rtype_reg == REQ_ALLOC)
                    begin
                        if (fit_exact)
                        begin
                            m_we       = 1'b1;
                            m_waddr    = chk_idx_reg;
                            m_wdata    = {1'b1, rd_len, rd_start};
                            free_next  = free_reg - size37;
                            used_next  = used_reg + size37;
                            addr_next  = rd_start_w[FIELD_ADDR_W-1:0];
                            state_next = S_DONE;
                        end
                        else if (count_reg >= CW'(MAX_BLOCKS))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // open a slot above the hit
                            p_next     = count_reg - CW'(1);
                            n_next     = count_reg - CW'(chk_idx_reg);
                            wv_next    = 1'b0;
                            up_next    = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    else if (!rd_busy)
                    begin
                        status_next = ST_BAD_ADDR;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // fetch the upper neighbor
                        m_re       = (CW'(chk_idx_reg) + CW'(1)) < count_reg;
                        m_raddr    = chk_idx_reg + IW'(1);
                        state_next = S_MERGE;
                    end
                end
                else
                begin
                    if (chk_v_reg)
                    begin
                        prev_next = m_rdata;
                    end
                    if (iss_reg < count_reg)
                    begin
                        m_re         = 1'b1;
                        m_raddr      = iss_reg[IW-1:0];
                        chk_v_next   = 1'b1;
                        chk_idx_next = iss_reg[IW-1:0];
                        iss_next     = iss_reg + CW'(1);
                    end
                    else
                    begin
                        chk_v_next  = 1'b0;
                        status_next = (rtype_reg == REQ_ALLOC) ? ST_NO_FIT : ST_BAD_ADDR;
                        state_next  = S_DONE;
                    end
                end
            end

            S_MERGE:
            begin
                m_we       = 1'b1;
                m_waddr    = merge_p ? (hit_reg - IW'(1)) : hit_reg;
                m_wdata    = {1'b0, merged_len, (merge_p ? prev_start : cur_start)};
                free_next  = free_reg + cur_len;
                used_next  = used_reg - cur_len;
                dsub_next  = {1'b0, merge_p} + {1'b0, merge_n};
                count_next = count_reg - CW'({1'b0, merge_p} + {1'b0, merge_n});
                p_next     = src_first;
                n_next     = count_reg - src_first;
                wv_next    = 1'b0;
                up_next    = 1'b0;
                state_next = (merge_p || merge_n) ? S_SHIFT : S_DONE;
            end

            S_SHIFT:
            begin
                if (wv_reg)
                begin
                    m_we    = 1'b1;
                    m_waddr = wdst_reg;
                    m_wdata = m_rdata;
                end
                if (n_reg != '0)
                begin
                    m_re    = 1'b1;
                    m_raddr = p_reg[IW-1:0];
                    wv_next = 1'b1;
                    if (up_reg)
                    begin
                        wdst_next = IW'(p_reg + CW'(1));
                        p_next    = p_reg - CW'(1);
                    end
                    else
                    begin
                        wdst_next = IW'(p_reg - CW'(dsub_reg));
                        p_next    = p_reg + CW'(1);
                    end
                    n_next = n_reg - CW'(1);
                end
                else
                begin
                    wv_next    = 1'b0;
                    state_next = up_reg ? S_SPLIT_LO : S_DONE;
                end
            end

            S_SPLIT_LO:
            begin
                m_we       = 1'b1;
                m_waddr    = hit_reg;
                m_wdata    = {1'b1, size37, cur_start};
                state_next = S_SPLIT_HI;
            end

            S_SPLIT_HI:
            begin
                m_we       = 1'b1;
                m_waddr    = hit_reg + IW'(1);
                m_wdata    = {1'b0, split_len, split_sum[AB-1:0]};
                count_next = count_reg + CW'(1);
                free_next  = free_reg - size37;
                used_next  = used_reg + size37;
                addr_next  = cur_start_w[FIELD_ADDR_W-1:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!outv_reg || out_ready)
                begin
                    outv_next            = 1'b1;
                    outd_next.alloc_addr = addr_reg;
                    outd_next.status     = status_reg;
                    outd_next.free_bytes = free_reg;
                    outd_next.used_bytes = used_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            rsize_reg <= REGION_SIZE_RST;
            shift_reg <= ALIGN_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_BASE:  base_reg  <= cfg_wdata[FIELD_ADDR_W-1:0];
                CFG_SIZE:  rsize_reg <= cfg_wdata;
                CFG_SHIFT: shift_reg <= cfg_wdata[SHIFT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            free_reg    <= '0;
            used_reg    <= '0;
            started_reg <= 1'b0;
            chk_v_reg   <= 1'b0;
            wv_reg      <= 1'b0;
            outv_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            used_reg    <= used_next;
            started_reg <= started_next;
            chk_v_reg   <= chk_v_next;
            wv_reg      <= wv_next;
            outv_reg    <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        addr_reg    <= addr_next;
        rtype_reg   <= rtype_next;
        size_reg    <= size_next;
        faddr_reg   <= faddr_next;
        iss_reg     <= iss_next;
        chk_idx_reg <= chk_idx_next;
        hit_reg     <= hit_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        wdst_reg    <= wdst_next;
        up_reg      <= up_next;
        dsub_reg    <= dsub_next;
        outd_reg    <= outd_next;
    end

    assign out_valid = outv_reg;
    assign out_data  = outd_reg;

endmodule

`default_nettype wire

// File: rtl/core/ffra_chk.sv
`default_nettype none

module ffra_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire ffra_pkg::rsp_t out_data
);

    import ffra_pkg::*;

    // one request in flight: a transfer drops ready on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.alloc_addr == '0)
        else $error("failed request reported an address");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_NOT_STARTED)
            |-> (out_data.free_bytes == '0) && (out_data.used_bytes == '0))
        else $error("stopped manager reported nonzero byte counts");

endmodule

bind first_fit_region_allocator ffra_chk u_ffra_chk (.*);

`default_nettype wire

// File: bench/first_fit_region_allocator_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module first_fit_region_allocator_tb;
    import ffra_pkg::*;

    localparam int NBLK      = 64;
    localparam int WATCH_MAX = 20000;

    // Models the allocator's block table and byte counts; holds the expected responses.
    class alloc_scoreboard;
        logic [35:0] base_q;
        logic [36:0] size_q;
        logic [4:0]  shift_q;
        logic [35:0] blk_addr [NBLK];
        logic [36:0] blk_size [NBLK];
        bit          blk_used [NBLK];
        int          nblk;
        logic [36:0] nfree;
        bit          running;
        rsp_t        pending [$];
        int          errors;

        function new();
            base_q = '0;
            size_q = REGION_SIZE_RST;
            shift_q = ALIGN_SHIFT_RST;
            nblk = 0;
            nfree = '0;
            running = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [36:0] v);
            case (idx)
                CFG_BASE:  base_q = v[35:0];
                CFG_SIZE:  size_q = v;
                CFG_SHIFT: shift_q = v[4:0];
                default: ;
            endcase
        endfunction

        function void remove_at(int k);
            for (int i = k; i + 1 < nblk; i++)
            begin
                blk_addr[i] = blk_addr[i+1];
                blk_size[i] = blk_size[i+1];
                blk_used[i] = blk_used[i+1];
            end
            nblk--;
        endfunction

        function status_t grant(logic [36:0] req, output logic [35:0] got);
            logic [63:0] align;
            logic [63:0] need;
            align = 64'd1 << shift_q;
            need = (64'(req) + align - 1) & ~(align - 1);
            if (need < align)
                need = align;
            got = '0;
            for (int i = 0; i < nblk; i++)
            begin
                if (blk_used[i] || 64'(blk_size[i]) < need)
                    continue;
                if (64'(blk_size[i]) != need)
                begin
                    if (nblk >= NBLK)
                        return ST_FULL;
                    for (int j = nblk; j > i; j--)
                    begin
                        blk_addr[j] = blk_addr[j-1];
                        blk_size[j] = blk_size[j-1];
                        blk_used[j] = blk_used[j-1];
                    end
                    nblk++;
                    blk_size[i] = need[36:0];
                    blk_addr[i+1] = blk_addr[i] + need[35:0];
                    blk_size[i+1] = blk_size[i+1] - need[36:0];
                    blk_used[i+1] = 0;
                end
                blk_used[i] = 1;
                nfree = nfree - need[36:0];
                got = blk_addr[i];
                return ST_OK;
            end
            return ST_NO_FIT;
        endfunction

        function status_t release_blk(logic [35:0] a);
            int k;
            k = -1;
            for (int i = 0; i < nblk; i++)
                if (blk_addr[i] == a)
                begin
                    k = i;
                    break;
                end
            if (k < 0 || !blk_used[k])
                return ST_BAD_ADDR;
            blk_used[k] = 0;
            nfree = nfree + blk_size[k];
            if (k > 0 && !blk_used[k-1]
                && 64'(blk_addr[k-1]) + 64'(blk_size[k-1]) == 64'(blk_addr[k]))
            begin
                blk_size[k-1] = blk_size[k-1] + blk_size[k];
                remove_at(k);
                k--;
            end
            if (k + 1 < nblk && !blk_used[k+1]
                && 64'(blk_addr[k]) + 64'(blk_size[k]) == 64'(blk_addr[k+1]))
            begin
                blk_size[k] = blk_size[k] + blk_size[k+1];
                remove_at(k + 1);
            end
            return ST_OK;
        endfunction

        function void note_request(req_t r);
            rsp_t        e;
            status_t     st;
            logic [35:0] a;
            logic [63:0] room;
            logic [63:0] len;
            logic [36:0] used;
            st = ST_OK;
            a = '0;
            if (r.req_type == REQ_START)
            begin
                if (running)
                    st = ST_ALREADY;
                else
                begin
                    room = (64'd1 << 36) - 64'(base_q);
                    len = 64'(size_q);
                    if (len > room)
                        len = room;
                    running = 1;
                    nblk = 0;
                    if (len != 0)
                    begin
                        blk_addr[0] = base_q;
                        blk_size[0] = len[36:0];
                        blk_used[0] = 0;
                        nblk = 1;
                    end
                    nfree = len[36:0];
                end
            end
            else if (!running)
                st = ST_NOT_STARTED;
            else if (r.req_type == REQ_ALLOC)
                st = grant(r.alloc_size, a);
            else if (r.req_type == REQ_FREE)
                st = release_blk(r.free_addr);
            else
            begin
                nblk = 0;
                nfree = '0;
                running = 0;
            end
            used = '0;
            for (int i = 0; i < nblk; i++)
                if (blk_used[i])
                    used = used + blk_size[i];
            e.alloc_addr = (st == ST_OK) ? a : '0;
            e.status = st;
            e.free_bytes = running ? nfree : '0;
            e.used_bytes = running ? used : '0;
            pending.push_back(e);
        endfunction

        task report(string what, logic [36:0] got, logic [36:0] want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_response(rsp_t r);
            rsp_t e;
            if (pending.size() == 0)
            begin
                report("unexpected response", 37'(r.status), '0);
                return;
            end
            e = pending.pop_front();
            if (r.alloc_addr !== e.alloc_addr) report("alloc_addr", 37'(r.alloc_addr), 37'(e.alloc_addr));
            if (r.status !== e.status) report("status", 37'(r.status), 37'(e.status));
            if (r.free_bytes !== e.free_bytes) report("free_bytes", r.free_bytes, e.free_bytes);
            if (r.used_bytes !== e.used_bytes) report("used_bytes", r.used_bytes, e.used_bytes);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [36:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    req_t        in_data;
    logic        out_valid;
    logic        out_ready;
    rsp_t        out_data;

    alloc_scoreboard sb;
    int          stall_left;
    bit          quiet;
    int          idle_cycles;
    logic [35:0] granted [$];

    first_fit_region_allocator DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // Check results, track granted addresses for later frees, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (out_data.status == ST_OK && out_data.alloc_addr != 0)
                    granted.push_back(out_data.alloc_addr);
                sb.check_response(out_data);
            end
            if (idle_cycles >= WATCH_MAX)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver stalls in bursts.
    always @(negedge clk)
    begin
        if (quiet)
            out_ready <= 1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 16) - 1;
            out_ready <= 0;
        end
        else
            out_ready <= 1;
    end

    task write_reg(cfg_idx_t idx, logic [36:0] v);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task send(req_type_t t, logic [36:0] sz, logic [35:0] a);
        req_t r;
        r.req_type = t;
        r.alloc_size = sz;
        r.free_addr = a;
        if (!quiet && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 16)) @(negedge clk);
        else
            @(negedge clk);
        in_valid <= 1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
        in_valid <= 0;
    endtask

    task drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function logic [36:0] rand_size(logic [4:0] sh);
        case ($urandom_range(0, 5))
            0: return 37'({$urandom, $urandom});
            1: return 37'($urandom_range(0, 3)) << sh;
            default: return 37'($urandom_range(0, 16) << sh) + 37'($urandom_range(0, 3));
        endcase
    endfunction

    task random_phase(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send(REQ_ALLOC, rand_size(sb.shift_q), 36'({$urandom, $urandom}));
            else if (pick < 85 && granted.size() > 0)
            begin
                pick = $urandom_range(0, granted.size() - 1);
                send(REQ_FREE, 37'({$urandom, $urandom}), granted[pick]);
                granted.delete(pick);
            end
            else if (pick < 92)
                send(REQ_FREE, 37'({$urandom, $urandom}), 36'({$urandom, $urandom}));
            else if (pick < 95)
                send(REQ_START, '0, '0);
            else if (pick < 97)
            begin
                send(REQ_STOP, '0, '0);
                send(REQ_START, '0, '0);
            end
            else
                send(REQ_ALLOC, '0, '0);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_wdata = '0;
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        stall_left = 0;
        quiet = 0;
        idle_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;

        // Directed: not-started, start twice, extremes of sizes, bad frees.
        send(REQ_ALLOC, '0, '0);
        send(REQ_FREE, '0, '0);
        send(REQ_STOP, '0, '0);
        send(REQ_START, '0, '0);
        send(REQ_START, '0, '0);
        send(REQ_ALLOC, '0, '0);
        send(REQ_ALLOC, '1, '1);
        send(REQ_ALLOC, 37'd4097, '0);
        send(REQ_FREE, '0, '1);
        send(REQ_FREE, '0, 36'd0);
        send(REQ_FREE, '0, 36'd0);
        send(REQ_FREE, '0, 36'd4096);
        send(REQ_ALLOC, 37'h10_0000_0000, '0);
        send(REQ_STOP, '0, '0);
        drain();

        // Small region, fine alignment: fill the table to force table-full.
        write_reg(CFG_SHIFT, 37'd0);
        write_reg(CFG_SIZE, 37'd100);
        write_reg(CFG_BASE, 37'd5);
        send(REQ_START, '0, '0);
        for (int i = 0; i < 66; i++)
            send(REQ_ALLOC, 37'd1, '0);
        send(REQ_FREE, '0, 36'd6);
        send(REQ_FREE, '0, 36'd7);
        send(REQ_STOP, '0, '0);
        drain();

        // Region past the top of the address space, and an empty region.
        write_reg(CFG_BASE, 37'hF_FFFF_F000);
        write_reg(CFG_SIZE, '1);
        write_reg(CFG_SHIFT, 37'd30);
        send(REQ_START, '0, '0);
        send(REQ_ALLOC, '0, '0);
        send(REQ_STOP, '0, '0);
        drain();
        write_reg(CFG_SIZE, '0);
        send(REQ_START, '0, '0);
        send(REQ_ALLOC, '0, '0);
        send(REQ_STOP, '0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            granted.delete();
            case (ph)
                0: begin write_reg(CFG_BASE, '0); write_reg(CFG_SIZE, 37'h10_0000_0000);
                         write_reg(CFG_SHIFT, 37'd12); end
                1: begin write_reg(CFG_BASE, 37'h123); write_reg(CFG_SIZE, 37'd400);
                         write_reg(CFG_SHIFT, 37'd2); end
                2: begin write_reg(CFG_BASE, 37'($urandom)); write_reg(CFG_SIZE, 37'd2000);
                         write_reg(CFG_SHIFT, 37'd4); end
                3: begin write_reg(CFG_BASE, 37'hF_FFFF_FFFF); write_reg(CFG_SIZE, 37'h1F_FFFF_FFFF);
                         write_reg(CFG_SHIFT, 37'd0); end
                4: begin write_reg(CFG_BASE, 37'h8_0000_0000); write_reg(CFG_SIZE, 37'd100000);
                         write_reg(CFG_SHIFT, 37'd8); end
                default: begin write_reg(CFG_BASE, '0); write_reg(CFG_SIZE, 37'd5000);
                         write_reg(CFG_SHIFT, 37'd6); quiet = 1; end
            endcase
            send(REQ_START, '0, '0);
            random_phase(240);
            if (ph == 2)
            begin
                // Hold off until every outstanding response has come back.
                while (sb.pending.size() != 0)
                    @(negedge clk);
                // Change alignment while running; affects later alloc rounding only.
                write_reg(CFG_SHIFT, 37'd3);
                random_phase(40);
            end
            send(REQ_STOP, '0, '0);
            drain();
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
